/* hdl/dual_wheel_encoder_period_capture_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the dual wheel encoder period capture block
// Shared property forms; the including module provides clk_i and rst_ni.
// ----------------------------------------------------------------------------
`ifndef DUAL_WHEEL_ENCODER_PERIOD_CAPTURE_DEFINES_SVH
`define DUAL_WHEEL_ENCODER_PERIOD_CAPTURE_DEFINES_SVH

// Same-cycle implication, checked out of reset
`define DWEPC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define DWEPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/dwepc_pkg.sv */
// ----------------------------------------------------------------------------
// dwepc_pkg
// Payload types, item codes and register constants of the wheel encoder block.
// ----------------------------------------------------------------------------
package dwepc_pkg;

  // Item codes
  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_PULSE = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;

  // Register map
  localparam logic REG_PULSES_PER_CAPTURE = 1'b0;
  localparam int unsigned PADDR_WIDTH = 3;
  localparam logic [7:0] DEFAULT_PERIOD = 8'd3;

  typedef struct packed {
    logic [1:0] mode;
    logic       side;
    logic       forward;
  } in_t;

  typedef struct packed {
    logic signed [31:0] total_pulses;
    logic [15:0]        period_ticks;
    logic               speed_valid;
    logic               captured_now;
    logic               timer_overflow;
  } out_t;

endpackage

/* hdl/dwepc_cfg.sv */
// ----------------------------------------------------------------------------
// dwepc_cfg
// APB register slave holding the pulses-per-capture setting.
// ----------------------------------------------------------------------------
module dwepc_cfg (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dwepc_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready,
  output logic [7:0]                        period_o
);
  import dwepc_pkg::*;

  logic [7:0] period_q, period_d;
  logic       hit;

  assign hit    = (paddr[2] == REG_PULSES_PER_CAPTURE);
  assign pready = 1'b1;

  always_comb begin
    period_d = period_q;
    if (psel && penable && pwrite && hit) begin
      period_d = pwdata[7:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= DEFAULT_PERIOD;
    end else begin
      period_q <= period_d;
    end
  end

  assign prdata   = hit ? {24'd0, period_q} : 32'd0;
  assign period_o = period_q;

endmodule

/* hdl/dwepc_channel.sv */
// ----------------------------------------------------------------------------
// dwepc_channel
// One wheel channel: pulse count, capture residue, tick timer, captured
// period and speed-valid flag, with the post-update status of the channel.
// ----------------------------------------------------------------------------
module dwepc_channel #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              sel_i,
  input  logic [1:0]        mode_i,
  input  logic              forward_i,
  input  logic [7:0]        period_i,
  output dwepc_pkg::out_t   status_o
);
  import dwepc_pkg::*;

  localparam logic [TIMER_WIDTH-1:0] TimerMax = '1;

  logic [COUNT_WIDTH-1:0] total_q, total_d;
  logic [7:0]             residue_q, residue_d;
  logic [TIMER_WIDTH-1:0] timer_q, timer_d;
  logic [TIMER_WIDTH-1:0] captured_q, captured_d;
  logic                   valid_q, valid_d;
  logic                   capture;
  logic [7:0]             period_eff;
  logic [8:0]             residue_inc;
  logic signed [63:0]     total_ext;
  logic [31:0]            period_ext;

  assign period_eff  = (period_i == 8'd0) ? 8'd1 : period_i;
  assign residue_inc = {1'b0, residue_q} + 9'd1;

  always_comb begin
    total_d    = total_q;
    residue_d  = residue_q;
    timer_d    = timer_q;
    captured_d = captured_q;
    valid_d    = valid_q;
    capture    = 1'b0;
    case (mode_i)
      MODE_TICK: begin
        if (timer_q != TimerMax) begin
          timer_d = timer_q + 1'b1;
        end
      end
      MODE_PULSE: begin
        if (sel_i) begin
          if (forward_i) begin
            total_d   = total_q + 1'b1;
            residue_d = (residue_inc >= {1'b0, period_eff}) ? 8'd0 : residue_inc[7:0];
          end else begin
            total_d   = total_q - 1'b1;
            residue_d = (residue_q == 8'd0 || residue_q >= period_eff) ?
                        period_eff - 8'd1 : residue_q - 8'd1;
          end
          // wrap of the residue closes one capture period
          if (residue_d == 8'd0) begin
            captured_d = timer_q;
            timer_d    = '0;
            valid_d    = 1'b1;
            capture    = 1'b1;
          end
        end
      end
      MODE_CLEAR: begin
        if (sel_i) begin
          valid_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q    <= '0;
      residue_q  <= '0;
      timer_q    <= '0;
      captured_q <= '0;
      valid_q    <= 1'b0;
    end else if (step_i) begin
      total_q    <= total_d;
      residue_q  <= residue_d;
      timer_q    <= timer_d;
      captured_q <= captured_d;
      valid_q    <= valid_d;
    end
  end

  // sign-extend or truncate the count to the 32-bit field
  assign total_ext  = 64'(signed'(total_d));
  assign period_ext = 32'(captured_d);

  always_comb begin
    status_o.total_pulses   = total_ext[31:0];
    status_o.period_ticks   = period_ext[15:0];
    status_o.speed_valid    = valid_d;
    status_o.captured_now   = capture;
    status_o.timer_overflow = (timer_d == TimerMax);
  end

endmodule

/* hdl/dual_wheel_encoder_period_capture.sv */
// ----------------------------------------------------------------------------
// dual_wheel_encoder_period_capture
// Two-channel wheel encoder pulse counter with timer-based period capture.
// ----------------------------------------------------------------------------
// Accepts one item per clock while the result register drains, and returns one
// result word per item, in order. An item is held in the input register, both
// wheel channels update their state from it as it moves on, and the chosen
// side's updated status is loaded into the result register, from which the
// result is offered. Input is taken whenever the input register is empty or
// its item moves on, which it does when the result register is free or being
// drained in the same cycle. Set pulses_per_capture over APB while the block
// is idle.
`include "dual_wheel_encoder_period_capture_defines.svh"

module dual_wheel_encoder_period_capture #(
  parameter int unsigned COUNT_WIDTH = 32,
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dwepc_pkg::in_t                    in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dwepc_pkg::out_t                   out_data_o,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dwepc_pkg::PADDR_WIDTH-1:0] paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);
  import dwepc_pkg::*;

  logic       in_valid_q, in_valid_d;
  in_t        in_q, in_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_q, out_d;
  logic       advance;
  logic [7:0] period;
  out_t       status_left, status_right;

  dwepc_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .period_o (period)
  );

  dwepc_channel #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_left (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .sel_i     (!in_q.side),
    .mode_i    (in_q.mode),
    .forward_i (in_q.forward),
    .period_i  (period),
    .status_o  (status_left)
  );

  dwepc_channel #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_right (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .sel_i     (in_q.side),
    .mode_i    (in_q.mode),
    .forward_i (in_q.forward),
    .period_i  (period),
    .status_o  (status_right)
  );

  // move the held item into the result register when it is free or draining
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  always_comb begin
    in_valid_d = in_valid_q;
    in_d       = in_q;
    if (in_ready_o) begin
      in_valid_d = in_valid_i;
      in_d       = in_data_i;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (advance) begin
      out_valid_d = 1'b1;
      out_d       = in_q.side ? status_right : status_left;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q  <= in_d;
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `DWEPC_ASSERT_NOW(a_capture_sets_valid, out_valid_q && out_q.captured_now, out_q.speed_valid, "capture without speed valid")
  `DWEPC_ASSERT_NOW(a_capture_clears_timer, out_valid_q && out_q.captured_now, !out_q.timer_overflow, "capture left timer saturated")
  `DWEPC_ASSERT_NEXT(a_advance_loads_result, advance, out_valid_q, "advanced item produced no result")

endmodule

/* verif/tb_dual_wheel_encoder_period_capture.sv */
// ----------------------------------------------------------------------------
// Testbench for the dual wheel encoder period capture block
// Feeds tick, pulse, clear and unused words through the valid/ready input,
// predicts each channel's count, residue, timer and captured period, and checks
// every result word in order. The capture setting is changed over APB between
// phases, including zero and the largest value. One long burst of ticks grows
// both timers before their values are captured.
// ----------------------------------------------------------------------------
module tb_dual_wheel_encoder_period_capture;
  timeunit 1ns;
  timeprecision 1ps;

  import dwepc_pkg::*;

  localparam int          CLK_PERIOD       = 8;
  localparam int          RESET_CYCLES     = 9;
  localparam int          SETTLE_CYCLES    = 4;
  localparam int          WATCHDOG_LIMIT   = 2000;
  localparam int          RANDOM_PER_PHASE = 60;
  localparam int          TICK_BURST       = 150;
  localparam logic [1:0]  MODE_UNUSED      = 2'd3;
  localparam logic [15:0] TIMER_TOP        = 16'hFFFF;

  typedef struct packed {
    logic [31:0] total;
    logic [7:0]  residue;
    logic [15:0] timer;
    logic [15:0] period;
    logic        valid;
  } wheel_t;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  in_t                    in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_t                   out_data_o;
  logic                   psel        = 1'b0;
  logic                   penable     = 1'b0;
  logic                   pwrite      = 1'b0;
  logic [PADDR_WIDTH-1:0] paddr       = '0;
  logic [31:0]            pwdata      = '0;
  logic [31:0]            prdata;
  logic                   pready;

  // predicted block state
  wheel_t     wheels [2];
  logic [7:0] capture_every = DEFAULT_PERIOD;

  in_t  pending_words[$];
  out_t expected_status[$];

  int unsigned gap_left, stall_left, quiet_cycles;
  bit          tx_steady, rx_steady;
  logic        last_side;
  logic [1:0]  heading;
  int unsigned words_sent, results_seen, mismatches;
  int unsigned captures_due, saturated_due, settings_written;

  dual_wheel_encoder_period_capture dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // Update the wheel state for one word and return the chosen side's status.
  function automatic out_t advance_wheels(in_t w);
    out_t       r;
    logic [8:0] span, res;
    logic       hit;
    int         k;
    hit  = 1'b0;
    span = (capture_every == 8'd0) ? 9'd1 : {1'b0, capture_every};
    case (w.mode)
      MODE_TICK: begin
        for (k = 0; k < 2; k++) begin
          if (wheels[k].timer != TIMER_TOP) wheels[k].timer++;
        end
      end
      MODE_PULSE: begin
        res = {1'b0, wheels[w.side].residue};
        if (w.forward) begin
          wheels[w.side].total++;
          res = (res + 9'd1 >= span) ? 9'd0 : res + 9'd1;
        end else begin
          wheels[w.side].total--;
          res = (res == 9'd0 || res >= span) ? span - 9'd1 : res - 9'd1;
        end
        wheels[w.side].residue = res[7:0];
        if (res[7:0] == 8'd0) begin
          wheels[w.side].period = wheels[w.side].timer;
          wheels[w.side].timer  = '0;
          wheels[w.side].valid  = 1'b1;
          hit = 1'b1;
        end
      end
      MODE_CLEAR: wheels[w.side].valid = 1'b0;
      default: ;
    endcase
    r.total_pulses   = wheels[w.side].total;
    r.period_ticks   = wheels[w.side].period;
    r.speed_valid    = wheels[w.side].valid;
    r.captured_now   = hit;
    r.timer_overflow = (wheels[w.side].timer == TIMER_TOP);
    return r;
  endfunction

  // Mostly no pause, some short ones, a few long ones.
  function automatic int unsigned pick_pause();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_t make_word(logic [1:0] mode, logic side, logic forward);
    in_t w;
    w.mode    = mode;
    w.side    = side;
    w.forward = forward;
    return w;
  endfunction

  // Runs of pulses on one side in one direction, mixed with ticks, clears and unused words.
  function automatic in_t random_word();
    int unsigned roll;
    logic [1:0]  mode;
    logic        side;
    roll = $urandom_range(0, 99);
    if (roll < 30)      mode = MODE_TICK;
    else if (roll < 88) mode = MODE_PULSE;
    else if (roll < 96) mode = MODE_CLEAR;
    else                mode = MODE_UNUSED;
    side = ($urandom_range(0, 99) < 75) ? last_side : ~last_side;
    last_side = side;
    if ($urandom_range(0, 99) < 15) heading[side] = ~heading[side];
    if (mode != MODE_PULSE) return make_word(mode, side, 1'($urandom()));
    return make_word(mode, side, heading[side]);
  endfunction

  // Driver: predict on acceptance, then present the next queued word.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        expected_status.push_back(advance_wheels(in_data_i));
        if (expected_status[$].captured_now) captures_due++;
        if (expected_status[$].timer_overflow) saturated_due++;
        words_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (pending_words.size() > 0) begin
          in_data_i  <= pending_words.pop_front();
          in_valid_i <= 1'b1;
          if ($urandom_range(0, 99) < 2) tx_steady = ~tx_steady;
          gap_left = tx_steady ? 0 : pick_pause();
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  task automatic flag_result(string why, out_t want, out_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s: expected total=%0d period=%0d valid=%0b cap=%0b ovf=%0b",
               $realtime, why, want.total_pulses, want.period_ticks, want.speed_valid,
               want.captured_now, want.timer_overflow);
    if (mismatches <= 10)
      $display("    got total=%0d period=%0d valid=%0b cap=%0b ovf=%0b",
               got.total_pulses, got.period_ticks, got.speed_valid,
               got.captured_now, got.timer_overflow);
  endtask

  // Monitor: check each result word against the oldest prediction.
  always @(posedge clk_i) begin
    out_t want;
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        results_seen++;
        if (expected_status.size() == 0) begin
          flag_result("result with nothing pending", '0, out_data_o);
        end else begin
          want = expected_status.pop_front();
          if (out_data_o.total_pulses !== want.total_pulses ||
              out_data_o.period_ticks !== want.period_ticks ||
              out_data_o.speed_valid !== want.speed_valid ||
              out_data_o.captured_now !== want.captured_now ||
              out_data_o.timer_overflow !== want.timer_overflow)
            flag_result("result mismatch", want, out_data_o);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready_i <= 1'b0;
      end else begin
        if ($urandom_range(0, 99) < 2) rx_steady = ~rx_steady;
        stall_left = rx_steady ? 0 : pick_pause();
        out_ready_i <= (stall_left == 0);
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (psel && penable && pready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog: no handshake for %0d cycles, %0d words queued, %0d results due",
               quiet_cycles, pending_words.size(), expected_status.size());
      $display("FAILURE");
      $finish;
    end
  end

  // Hold until every queued word is in and every result is out.
  task automatic drain();
    do @(posedge clk_i);
    while (pending_words.size() != 0 || in_valid_i || expected_status.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_capture_every(logic [7:0] value);
    logic [31:0] data;
    drain();
    data       = $urandom();
    data[7:0]  = value;
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_WIDTH'(4 * REG_PULSES_PER_CAPTURE);
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i);
    while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    capture_every = value;
    settings_written++;
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  phase_period [7];
    int unsigned ticks, n, p;
    wheels[0] = '0;
    wheels[1] = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    last_side = 1'b0;
    heading   = 2'b11;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // default period of three: capture on the third up pulse and on the third down pulse
    pending_words.push_back(make_word(MODE_TICK, 1'b0, 1'b0));
    pending_words.push_back(make_word(MODE_TICK, 1'b1, 1'b1));
    repeat (3) pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b1));
    repeat (3) pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_UNUSED, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_UNUSED, 1'b0, 1'b1));

    // zero period acts as one: every pulse captures
    write_capture_every(8'd0);
    pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_TICK, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_CLEAR, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b1));

    // build residues under the widest period, then shrink it below them
    write_capture_every(8'd255);
    repeat (5) pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b0));
    write_capture_every(8'd4);
    pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b0));

    // run a long tick burst, then capture the grown timer values
    write_capture_every(8'd1);
    ticks = 0;
    while (ticks < TICK_BURST) begin
      if ($urandom_range(0, 199) == 0) begin
        pending_words.push_back(make_word(($urandom_range(0, 1) != 0) ? MODE_CLEAR
                                          : MODE_UNUSED, 1'($urandom()), 1'($urandom())));
      end else begin
        pending_words.push_back(make_word(MODE_TICK, 1'($urandom()), 1'($urandom())));
        ticks++;
      end
    end
    pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b1));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b0));
    pending_words.push_back(make_word(MODE_PULSE, 1'b0, 1'b0));
    pending_words.push_back(make_word(MODE_PULSE, 1'b1, 1'b1));
    pending_words.push_back(make_word(MODE_TICK, 1'b0, 1'b0));

    // random phases, one per capture setting
    phase_period = '{8'd1, 8'd2, DEFAULT_PERIOD, 8'd255, 8'd0,
                     8'($urandom_range(4, 16)), 8'($urandom_range(1, 255))};
    for (p = 0; p < 7; p++) begin
      write_capture_every(phase_period[p]);
      for (n = 0; n < RANDOM_PER_PHASE; n++) begin
        pending_words.push_back(random_word());
        // hold the sender until the results catch up
        if (p % 2 == 0 && n == RANDOM_PER_PHASE / 2) drain();
      end
    end

    drain();
    repeat (10) @(posedge clk_i);
    $display("Sent %0d words across %0d capture settings; %0d captures, %0d saturated reports",
             words_sent, settings_written, captures_due, saturated_due);
    $display("Checked %0d results, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0 && expected_status.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+hdl
hdl/dwepc_pkg.sv
hdl/dwepc_cfg.sv
hdl/dwepc_channel.sv
hdl/dual_wheel_encoder_period_capture.sv
verif/tb_dual_wheel_encoder_period_capture.sv
